[rtl/trapezoid_window_clipper_top_defines.svh]
// Assertion macros for the trapezoid window clipper.
`ifndef TRAPEZOID_WINDOW_CLIPPER_TOP_DEFINES_SVH
`define TRAPEZOID_WINDOW_CLIPPER_TOP_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define TWC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define TWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

[rtl/twc_pkg.sv]
// ----------------------------------------------------------------------------
// twc_pkg
// Types and constants shared by the trapezoid window clipper modules.
// ----------------------------------------------------------------------------
`default_nettype none
package twc_pkg;

  localparam int MaxPieces = 3;

  typedef enum logic [2:0] {
    REG_WINDOW_LEFT   = 3'd0,
    REG_WINDOW_RIGHT  = 3'd1,
    REG_WINDOW_BOTTOM = 3'd2,
    REG_WINDOW_TOP    = 3'd3,
    REG_ORIENTATION   = 3'd4,
    REG_OFFSET_X      = 3'd5,
    REG_OFFSET_Y      = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] right_x;
    logic signed [31:0] bottom_y;
    logic signed [31:0] top_y;
    logic [3:0]         side_code;
  } in_item_t;

  typedef struct packed {
    logic               is_trap;
    logic signed [31:0] corner_x0;
    logic signed [31:0] corner_x1;
    logic signed [31:0] corner_x2;
    logic signed [31:0] corner_x3;
    logic signed [31:0] corner_y0;
    logic signed [31:0] corner_y1;
    logic signed [31:0] corner_y2;
    logic signed [31:0] corner_y3;
    logic               last_piece;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] wl;
    logic signed [31:0] wr;
    logic signed [31:0] wb;
    logic signed [31:0] wt;
    logic [2:0]         orient;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
  } cfg_t;

  // Exact-width coordinates inside the pipeline.
  typedef logic signed [35:0] coord_t;

  // One band of the clipped shape, before orientation.
  typedef struct packed {
    logic   is_trap;
    coord_t x0;
    coord_t x1;
    coord_t x2;
    coord_t x3;
    coord_t y0;
    coord_t y1;
    logic   last;
  } piece_t;

  // Clipped trapezoid with its cut heights, output of the clip stages.
  typedef struct packed {
    logic              is_box;
    logic              empty;
    logic signed [1:0] ls;
    logic signed [1:0] rs;
    coord_t            x1;
    coord_t            x2;
    coord_t            pl;
    coord_t            pr;
    coord_t            y1;
    coord_t            cut1;
    coord_t            cut2;
    coord_t            cut3;
    logic [1:0]        n;
  } clip_t;

  function automatic logic signed [1:0] slope_of(input logic [1:0] c);
    logic signed [1:0] s;
    unique case (c)
      2'd0: s = 2'sd0;
      2'd1: s = 2'sd1;
      default: s = -2'sd1;
    endcase
    return s;
  endfunction

  // Value times a slope of -1, 0 or +1.
  function automatic coord_t smul(input logic signed [1:0] s, input coord_t v);
    coord_t r;
    if (s == 2'sd0) r = '0;
    else if (s == 2'sd1) r = v;
    else r = -v;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/twc_regs.sv]
// ----------------------------------------------------------------------------
// twc_regs
// APB register file holding the clip window, orientation and offset.
// ----------------------------------------------------------------------------
`default_nettype none
module twc_regs
  import twc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  reg_index_t idx;
  logic       wr_en;

  assign idx   = reg_index_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wl     <= 32'sh8000_0000;
      cfg.wr     <= 32'sh7FFF_FFFF;
      cfg.wb     <= 32'sh8000_0000;
      cfg.wt     <= 32'sh7FFF_FFFF;
      cfg.orient <= 3'd0;
      cfg.ox     <= '0;
      cfg.oy     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW_LEFT:   cfg.wl     <= pwdata;
        REG_WINDOW_RIGHT:  cfg.wr     <= pwdata;
        REG_WINDOW_BOTTOM: cfg.wb     <= pwdata;
        REG_WINDOW_TOP:    cfg.wt     <= pwdata;
        REG_ORIENTATION:   cfg.orient <= pwdata[2:0];
        REG_OFFSET_X:      cfg.ox     <= pwdata;
        REG_OFFSET_Y:      cfg.oy     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_LEFT:   prdata = cfg.wl;
      REG_WINDOW_RIGHT:  prdata = cfg.wr;
      REG_WINDOW_BOTTOM: prdata = cfg.wb;
      REG_WINDOW_TOP:    prdata = cfg.wt;
      REG_ORIENTATION:   prdata = {29'd0, cfg.orient};
      REG_OFFSET_X:      prdata = cfg.ox;
      REG_OFFSET_Y:      prdata = cfg.oy;
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/twc_clip.sv]
// ----------------------------------------------------------------------------
// twc_clip
// Three-stage clip pipeline: y clamp, window crossings, cut ordering.
// ----------------------------------------------------------------------------
`default_nettype none
module twc_clip
  import twc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          clip_valid,
  input  wire logic     clip_ready,
  output clip_t         clip_data
);

  // Stage A registers: y clamp and empty checks.
  logic              a_valid;
  logic              a_box, a_empty;
  logic signed [1:0] a_ls, a_rs;
  coord_t            a_x1, a_x2, a_y1, a_y2, a_pl, a_pr;
  // Stage B registers: crossings resolved.
  logic              b_valid;
  clip_t             b_d;
  coord_t            b_c1, b_c2;
  logic              b_h1, b_h2;

  logic adv_a, adv_b, adv_c;
  assign adv_c    = !clip_valid || clip_ready;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign in_ready = adv_a;

  // Stage A logic.
  always_ff @(posedge clk) begin
    coord_t            x1, x2, y1, y2, pl, pr, wl, wr, wb, wt;
    logic signed [1:0] ls, rs;
    logic              box, empty;
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= in_valid;
    end
    if (adv_a) begin
      x1 = coord_t'(in_data.left_x);
      x2 = coord_t'(in_data.right_x);
      y1 = coord_t'(in_data.bottom_y);
      y2 = coord_t'(in_data.top_y);
      wl = coord_t'(cfg.wl);
      wr = coord_t'(cfg.wr);
      wb = coord_t'(cfg.wb);
      wt = coord_t'(cfg.wt);
      ls = slope_of(in_data.side_code[3:2]);
      rs = slope_of(in_data.side_code[1:0]);
      box = (in_data.side_code == 4'd0);
      pl = (ls == 2'sd1) ? y1 : y2;
      pr = (rs == 2'sd1) ? y2 : y1;
      if (box) begin
        if (x1 < wl) x1 = wl;
        if (x2 > wr) x2 = wr;
        if (y1 < wb) y1 = wb;
        if (y2 > wt) y2 = wt;
        empty = (x1 > x2) || (y1 > y2);
      end else begin
        if (y1 < wb) begin
          if (ls == 2'sd1) begin x1 = x1 + (wb - y1); pl = wb; end
          if (rs == -2'sd1) begin x2 = x2 - (wb - y1); pr = wb; end
          y1 = wb;
        end
        if (y2 > wt) begin
          if (ls == -2'sd1) begin x1 = x1 + (y2 - wt); pl = wt; end
          if (rs == 2'sd1) begin x2 = x2 - (y2 - wt); pr = wt; end
          y2 = wt;
        end
        empty = (y1 > y2) || (x1 >= wr && (ls != 0 || x1 > wr)) ||
                (x2 <= wl && (rs != 0 || x2 < wl));
      end
      a_box <= box; a_empty <= empty; a_ls <= ls; a_rs <= rs;
      a_x1 <= x1; a_x2 <= x2; a_y1 <= y1; a_y2 <= y2; a_pl <= pl; a_pr <= pr;
    end
  end

  // Stage B: find the crossings of the window edges.
  always_ff @(posedge clk) begin
    coord_t y1, y2, cy, c1, c2, wl, wr;
    logic   h1, h2;
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv_b) begin
      b_valid <= a_valid;
    end
    if (adv_b) begin
      wl = coord_t'(cfg.wl);
      wr = coord_t'(cfg.wr);
      y1 = a_y1; y2 = a_y2; h1 = 1'b0; h2 = 1'b0; c1 = '0; c2 = '0;
      if (!a_box && a_ls != 0) begin
        if (a_x2 > wr) begin
          cy = a_pl + smul(a_ls, wr - a_x1);
          if (cy > y1 && cy < y2) begin
            if (a_ls == 2'sd1) y2 = cy; else y1 = cy;
          end
        end
        if (a_x1 < wl) begin
          cy = a_pl + smul(a_ls, wl - a_x1);
          if (cy > y1 && cy < y2) begin h1 = 1'b1; c1 = cy; end
        end
      end
      if (!a_box && a_rs != 0) begin
        if (a_x1 < wl) begin
          cy = a_pr + smul(a_rs, wl - a_x2);
          if (cy > y1 && cy < y2) begin
            if (a_rs == 2'sd1) y1 = cy; else y2 = cy;
          end
        end
        if (a_x2 > wr) begin
          cy = a_pr + smul(a_rs, wr - a_x2);
          h2 = 1'b1; c2 = cy;
        end
      end
      b_d.is_box <= a_box; b_d.empty <= a_empty; b_d.ls <= a_ls; b_d.rs <= a_rs;
      b_d.x1 <= a_x1; b_d.x2 <= a_x2; b_d.pl <= a_pl; b_d.pr <= a_pr;
      b_d.y1 <= y1; b_d.cut1 <= '0; b_d.cut2 <= '0; b_d.cut3 <= y2; b_d.n <= 2'd0;
      b_c1 <= c1; b_c2 <= c2; b_h1 <= h1; b_h2 <= h2;
    end
  end

  // Stage C: order the cut heights.
  always_ff @(posedge clk) begin
    clip_t  d;
    logic   h2;
    if (rst) begin
      clip_valid <= 1'b0;
    end else if (adv_c) begin
      clip_valid <= b_valid && !b_d.empty;
    end
    if (adv_c) begin
      d  = b_d;
      // The left-crossing cut was checked against the narrower band already;
      // check the right-crossing cut against the final bottom and top.
      h2 = b_h2 && (b_c2 > d.y1) && (b_c2 < d.cut3);
      if (d.is_box) begin
        d.cut1 = d.cut3;
        d.n = 2'd1;
      end else if (b_h1 && h2) begin
        if (b_c2 < b_c1) begin
          d.cut1 = b_c2; d.cut2 = b_c1; d.cut3 = b_d.cut3; d.n = 2'd3;
        end else if (b_c2 == b_c1) begin
          d.cut1 = b_c1; d.cut2 = b_d.cut3; d.n = 2'd2;
        end else begin
          d.cut1 = b_c1; d.cut2 = b_c2; d.cut3 = b_d.cut3; d.n = 2'd3;
        end
      end else if (b_h1 || h2) begin
        d.cut1 = b_h1 ? b_c1 : b_c2; d.cut2 = b_d.cut3; d.n = 2'd2;
      end else begin
        d.cut1 = b_d.cut3; d.n = 2'd1;
      end
      clip_data <= d;
    end
  end

endmodule
`default_nettype wire

[rtl/twc_emit.sv]
// ----------------------------------------------------------------------------
// twc_emit
// Walks a clipped item's bands, one piece a cycle unless stalled, with band
// edges computed in a register stage, then orients and offsets each piece.
// ----------------------------------------------------------------------------
`default_nettype none
module twc_emit
  import twc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  clip_valid,
  output logic       clip_ready,
  input  wire clip_t clip_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  logic [1:0] k;
  logic       p_valid;
  piece_t     p;
  logic       adv_p, adv_o;
  coord_t     yprev, ycur, plo, phi, lo, hi;
  logic       is_last;

  assign adv_o = !out_valid || out_ready;
  assign adv_p = !p_valid || adv_o;
  assign is_last = ({1'b0, k} + 3'd1 == {1'b0, clip_data.n});
  assign clip_ready = adv_p && is_last;

  function automatic coord_t edge_x(input clip_t d, input coord_t y, input logic left);
    coord_t v;
    if (left) begin
      v = d.x1 + smul(d.ls, y - d.pl);
      if (v < coord_t'(cfg.wl)) v = coord_t'(cfg.wl);
    end else begin
      v = d.x2 + smul(d.rs, y - d.pr);
      if (v > coord_t'(cfg.wr)) v = coord_t'(cfg.wr);
    end
    return v;
  endfunction

  always_comb begin
    unique case (k)
      2'd0: begin yprev = clip_data.y1;   ycur = clip_data.cut1; end
      2'd1: begin yprev = clip_data.cut1; ycur = clip_data.cut2; end
      default: begin yprev = clip_data.cut2; ycur = clip_data.cut3; end
    endcase
    if (clip_data.is_box) begin
      plo = clip_data.x1; phi = clip_data.x2; lo = plo; hi = phi;
    end else begin
      plo = edge_x(clip_data, yprev, 1'b1);
      phi = edge_x(clip_data, yprev, 1'b0);
      lo  = edge_x(clip_data, ycur, 1'b1);
      hi  = edge_x(clip_data, ycur, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 2'd0;
      p_valid <= 1'b0;
    end else if (adv_p) begin
      p_valid <= clip_valid;
      if (clip_valid) k <= is_last ? 2'd0 : k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p) begin
      p.is_trap <= !(plo == lo && phi == hi);
      p.x0 <= plo; p.x1 <= lo; p.x2 <= hi; p.x3 <= phi;
      p.y0 <= yprev; p.y1 <= ycur;
      p.last <= is_last;
    end
  end

  // Orientation and offset stage.
  always_ff @(posedge clk) begin
    coord_t x0, x1, x2, x3, y0, y1, z, u0, u1, v0, v1, ox, oy;
    logic   swp, nx, ny;
    logic signed [1:0] ca, cb, cd, ce;
    out_item_t o;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_o) begin
      out_valid <= p_valid;
    end
    if (adv_o) begin
      swp = cfg.orient[0]; nx = cfg.orient[1]; ny = cfg.orient[2];
      ox = coord_t'(cfg.ox); oy = coord_t'(cfg.oy);
      x0 = p.x0; x1 = p.x1; x2 = p.x2; x3 = p.x3; y0 = p.y0; y1 = p.y1;
      o = '0;
      if (!p.is_trap) begin
        if (swp) begin u0 = y0; u1 = y1; v0 = x0; v1 = x2; end
        else begin u0 = x0; u1 = x2; v0 = y0; v1 = y1; end
        if (nx) begin z = u0; u0 = -u1; u1 = -z; end
        if (ny) begin z = v0; v0 = -v1; v1 = -z; end
        o.corner_x0 = 32'(u0 + ox);
        o.corner_x1 = 32'(u1 + ox);
        o.corner_y0 = 32'(v0 + oy);
        o.corner_y1 = 32'(v1 + oy);
      end else begin
        ca = 2'sd0; cb = 2'sd0; cd = 2'sd0; ce = 2'sd0;
        if (swp) begin
          cb = nx ? -2'sd1 : 2'sd1; cd = ny ? -2'sd1 : 2'sd1;
        end else begin
          ca = nx ? -2'sd1 : 2'sd1; ce = ny ? -2'sd1 : 2'sd1;
        end
        if (ce == 2'sd1 || cb == -2'sd1) begin
          if (ca == -2'sd1 || cd == -2'sd1) begin
            z = x0; x0 = x3; x3 = z;
            z = x1; x1 = x2; x2 = z;
          end
        end else begin
          if (ca == 2'sd1 || cd == 2'sd1) begin
            z = x0; x0 = x1; x1 = z;
            z = x2; x2 = x3; x3 = z;
          end else begin
            z = x0; x0 = x2; x2 = z;
            z = x1; x1 = x3; x3 = z;
          end
          z = y0; y0 = y1; y1 = z;
        end
        o.is_trap = 1'b1;
        if (!swp) begin
          o.corner_x0 = 32'(smul(ca, x0) + ox);
          o.corner_x1 = 32'(smul(ca, x1) + ox);
          o.corner_x2 = 32'(smul(ca, x2) + ox);
          o.corner_x3 = 32'(smul(ca, x3) + ox);
          o.corner_y0 = 32'(smul(ce, y0) + oy);
          o.corner_y3 = 32'(smul(ce, y0) + oy);
          o.corner_y1 = 32'(smul(ce, y1) + oy);
          o.corner_y2 = 32'(smul(ce, y1) + oy);
        end else begin
          o.corner_y0 = 32'(smul(cd, x0) + oy);
          o.corner_y1 = 32'(smul(cd, x1) + oy);
          o.corner_y2 = 32'(smul(cd, x2) + oy);
          o.corner_y3 = 32'(smul(cd, x3) + oy);
          o.corner_x0 = 32'(smul(cb, y0) + ox);
          o.corner_x3 = 32'(smul(cb, y0) + ox);
          o.corner_x1 = 32'(smul(cb, y1) + ox);
          o.corner_x2 = 32'(smul(cb, y1) + ox);
        end
      end
      o.last_piece = p.last;
      out_data <= o;
    end
  end

endmodule
`default_nettype wire

[rtl/trapezoid_window_clipper_top.sv]
// Path: an accepted item passes clip stages A, B and C, the emit piece
// register and the orientation register before its first piece is shown.
// Throughput: one piece per cycle while out_ready allows; an item gives 1
// to 3 pieces from the band walk in the emit stage; empty items give none.
// Reset: synchronous active-high rst clears all valid bits and loads the
// window to the full range, orientation to identity and offsets to zero.
`default_nettype none
`include "trapezoid_window_clipper_top_defines.svh"
module trapezoid_window_clipper_top
  import twc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg;
  logic  clip_valid, clip_ready;
  clip_t clip_data;

  assign pready = 1'b1;

  twc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  twc_clip u_clip (
    .clk, .rst, .cfg, .in_valid, .in_ready, .in_data,
    .clip_valid, .clip_ready, .clip_data
  );

  twc_emit u_emit (
    .clk, .rst, .cfg, .clip_valid, .clip_ready, .clip_data,
    .out_valid, .out_ready, .out_data
  );

  `TWC_ASSERT_IMP(a_clip_count, clip_valid, clip_data.n != 2'd0)
  `TWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TWC_ASSERT_IMP(a_box_one_band, clip_valid && clip_data.is_box, clip_data.n == 2'd1)

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Trapezoid window clipper testbench
// Drives trapezoids and boxes through the block under several window,
// orientation and offset settings, predicts every clipped piece and compares
// each output item as a whole, in order, with the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import twc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trapezoid_window_clipper_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers.
  longint win_l, win_r, win_b, win_t, offs_x, offs_y;
  bit [2:0] orient;

  out_item_t pending_pieces[$];
  int        error_count = 0;
  int        hold_cycles = 0;
  bit        gaps_on = 1'b1;

  function automatic longint sext(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic out_item_t make_box(longint xl, longint xh, longint yl, longint yh);
    out_item_t o;
    longint u0, u1, v0, v1, t;
    o = '0;
    if (orient[0]) begin
      u0 = yl; u1 = yh; v0 = xl; v1 = xh;
    end else begin
      u0 = xl; u1 = xh; v0 = yl; v1 = yh;
    end
    if (orient[1]) begin
      t = u0; u0 = -u1; u1 = -t;
    end
    if (orient[2]) begin
      t = v0; v0 = -v1; v1 = -t;
    end
    o.corner_x0 = 32'(u0 + offs_x);
    o.corner_x1 = 32'(u1 + offs_x);
    o.corner_y0 = 32'(v0 + offs_y);
    o.corner_y1 = 32'(v1 + offs_y);
    return o;
  endfunction

  function automatic out_item_t make_trap(longint x0, longint x1, longint x2, longint x3,
                                          longint y0, longint y1);
    out_item_t o;
    longint ca, cb, cd, ce, z;
    longint lx[4], ly[4];
    ca = 0; cb = 0; cd = 0; ce = 0;
    if (orient[0]) begin
      cb = orient[1] ? -1 : 1;
      cd = orient[2] ? -1 : 1;
    end else begin
      ca = orient[1] ? -1 : 1;
      ce = orient[2] ? -1 : 1;
    end
    // Reorder the corners so that the sequence keeps its winding sense.
    if (ce > 0 || cb < 0) begin
      if (ca < 0 || cd < 0) begin
        z = x0; x0 = x3; x3 = z;
        z = x1; x1 = x2; x2 = z;
      end
    end else begin
      if (ca > 0 || cd > 0) begin
        z = x0; x0 = x1; x1 = z;
        z = x2; x2 = x3; x3 = z;
      end else begin
        z = x0; x0 = x2; x2 = z;
        z = x1; x1 = x3; x3 = z;
      end
      z = y0; y0 = y1; y1 = z;
    end
    if (ca != 0) begin
      lx[0] = x0 * ca + offs_x; lx[1] = x1 * ca + offs_x;
      lx[2] = x2 * ca + offs_x; lx[3] = x3 * ca + offs_x;
      ly[0] = y0 * ce + offs_y; ly[3] = ly[0];
      ly[1] = y1 * ce + offs_y; ly[2] = ly[1];
    end else begin
      ly[0] = x0 * cd + offs_y; ly[1] = x1 * cd + offs_y;
      ly[2] = x2 * cd + offs_y; ly[3] = x3 * cd + offs_y;
      lx[0] = y0 * cb + offs_x; lx[3] = lx[0];
      lx[1] = y1 * cb + offs_x; lx[2] = lx[1];
    end
    o = '0;
    o.is_trap = 1'b1;
    o.corner_x0 = 32'(lx[0]); o.corner_x1 = 32'(lx[1]);
    o.corner_x2 = 32'(lx[2]); o.corner_x3 = 32'(lx[3]);
    o.corner_y0 = 32'(ly[0]); o.corner_y1 = 32'(ly[1]);
    o.corner_y2 = 32'(ly[2]); o.corner_y3 = 32'(ly[3]);
    return o;
  endfunction

  function automatic longint slope(logic [1:0] c);
    if (c == 2'd0) return 0;
    return (c == 2'd1) ? 1 : -1;
  endfunction

  // Clips one item and queues the pieces it should produce.
  task automatic predict_pieces(in_item_t it);
    longint x1, x2, y1, y2, ls, rs, pl, pr, cy, lo, hi, plo, phi, yprev;
    longint cut[4];
    int n, k;
    out_item_t o;
    x1 = sext(it.left_x); x2 = sext(it.right_x);
    y1 = sext(it.bottom_y); y2 = sext(it.top_y);
    n = 0;
    if (it.side_code == 4'd0) begin
      if (x1 < win_l) x1 = win_l;
      if (x2 > win_r) x2 = win_r;
      if (y1 < win_b) y1 = win_b;
      if (y2 > win_t) y2 = win_t;
      if (x1 > x2 || y1 > y2) return;
      o = make_box(x1, x2, y1, y2);
      o.last_piece = 1'b1;
      pending_pieces.push_back(o);
      return;
    end
    ls = slope(it.side_code[3:2]);
    rs = slope(it.side_code[1:0]);
    pl = (ls == 1) ? y1 : y2;
    pr = (rs == 1) ? y2 : y1;
    if (y1 < win_b) begin
      if (ls == 1) begin x1 += win_b - y1; pl = win_b; end
      if (rs == -1) begin x2 -= win_b - y1; pr = win_b; end
      y1 = win_b;
    end
    if (y2 > win_t) begin
      if (ls == -1) begin x1 += y2 - win_t; pl = win_t; end
      if (rs == 1) begin x2 -= y2 - win_t; pr = win_t; end
      y2 = win_t;
    end
    if (y1 > y2) return;
    if (x1 >= win_r && (ls != 0 || x1 > win_r)) return;
    if (x2 <= win_l && (rs != 0 || x2 < win_l)) return;
    if (ls != 0) begin
      if (x2 > win_r) begin
        cy = pl + ls * (win_r - x1);
        if (cy > y1 && cy < y2) begin
          if (ls > 0) y2 = cy; else y1 = cy;
        end
      end
      if (x1 < win_l) begin
        cy = pl + ls * (win_l - x1);
        if (cy > y1 && cy < y2) begin n++; cut[n] = cy; end
      end
    end
    if (rs != 0) begin
      if (x1 < win_l) begin
        cy = pr + rs * (win_l - x2);
        if (cy > y1 && cy < y2) begin
          if (rs > 0) y1 = cy; else y2 = cy;
        end
      end
      if (x2 > win_r) begin
        cy = pr + rs * (win_r - x2);
        if (cy > y1 && cy < y2) begin
          if (n != 0 && cy <= cut[1]) begin
            if (cy < cut[1]) begin n++; cut[n] = cut[1]; cut[1] = cy; end
          end else begin
            n++; cut[n] = cy;
          end
        end
      end
    end
    n++; cut[n] = y2;
    lo = x1 + ls * (y1 - pl);
    if (lo < win_l) lo = win_l;
    hi = x2 + rs * (y1 - pr);
    if (hi > win_r) hi = win_r;
    for (k = 1; k <= n; k++) begin
      yprev = y1; plo = lo; phi = hi;
      y1 = cut[k];
      lo = x1 + ls * (y1 - pl);
      if (lo < win_l) lo = win_l;
      hi = x2 + rs * (y1 - pr);
      if (hi > win_r) hi = win_r;
      if (plo == lo && phi == hi) o = make_box(lo, hi, yprev, y1);
      else o = make_trap(plo, lo, hi, phi, yprev, y1);
      o.last_piece = (k == n);
      pending_pieces.push_back(o);
    end
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WINDOW_LEFT:   win_l = sext(val);
      REG_WINDOW_RIGHT:  win_r = sext(val);
      REG_WINDOW_BOTTOM: win_b = sext(val);
      REG_WINDOW_TOP:    win_t = sext(val);
      REG_ORIENTATION:   orient = val[2:0];
      REG_OFFSET_X:      offs_x = sext(val);
      REG_OFFSET_Y:      offs_y = sext(val);
      default: ;
    endcase
  endtask

  // Waits for every expected piece, then for the pipeline to drain.
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(longint l, longint r, longint b, longint t,
                            bit [2:0] o, longint ox, longint oy);
    drain_pipeline();
    reg_write(REG_WINDOW_LEFT, 32'(l));
    reg_write(REG_WINDOW_RIGHT, 32'(r));
    reg_write(REG_WINDOW_BOTTOM, 32'(b));
    reg_write(REG_WINDOW_TOP, 32'(t));
    reg_write(REG_ORIENTATION, 32'(o));
    reg_write(REG_OFFSET_X, 32'(ox));
    reg_write(REG_OFFSET_Y, 32'(oy));
  endtask

  // The valid stays high between items of a burst; a gap drops it.
  task automatic send_item(in_item_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pieces(it);
  endtask

  function automatic in_item_t make_item(longint l, longint r, longint b, longint t,
                                         logic [3:0] sc);
    in_item_t it;
    it.left_x = 32'(l); it.right_x = 32'(r);
    it.bottom_y = 32'(b); it.top_y = 32'(t);
    it.side_code = sc;
    return it;
  endfunction

  // Mostly a well-formed trapezoid near the window so that clipping paths are hit; one in ten is random.
  function automatic in_item_t random_shape;
    longint b, h, l, w;
    logic [3:0] sc;
    in_item_t it;
    if ($urandom_range(0, 9) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, 4'($urandom)};
      return it;
    end
    sc = 4'($urandom);
    b = longint'($urandom_range(0, 200)) - 100;
    h = $urandom_range(0, 80);
    l = longint'($urandom_range(0, 200)) - 100;
    w = $urandom_range(0, 200);
    if (sc[3:2] == 2'd2 || sc[3:2] == 2'd3) l -= h;
    return make_item(l, l + w + h, b, b + h, sc);
  endfunction

  task automatic test_directed_reset_window;
    logic [3:0] sc;
    send_item(make_item(-10, 10, -5, 5, 4'd0));
    send_item(make_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 4'd0));
    send_item(make_item(0, 20, 0, 10, 4'b0110));
    send_item(make_item(5, 4, 0, 1, 4'd0));
    for (int i = 0; i < 16; i++) begin
      sc = 4'(i);
      send_item(make_item(-20, 40, -10, 10, sc));
    end
  endtask

  task automatic test_directed_small_window;
    set_config(-10, 10, -10, 10, 3'd5, 32'sh7fffffff, 32'sh80000000);
    send_item(make_item(-40, 40, -40, 40, 4'b0101));
    send_item(make_item(-40, 40, -40, 40, 4'b1010));
    send_item(make_item(-30, 30, -20, 20, 4'b0110));
    send_item(make_item(-30, 30, -20, 20, 4'b1001));
    send_item(make_item(10, 30, 0, 5, 4'b0100));
    send_item(make_item(10, 30, 0, 5, 4'd0));
    send_item(make_item(-30, -10, 0, 5, 4'b0001));
    send_item(make_item(-5, 5, 20, 30, 4'b0101));
    send_item(make_item(-5, 5, 30, 20, 4'd0));
  endtask

  task automatic test_random_orientations;
    bit [2:0] o;
    for (int phase = 0; phase < 8; phase++) begin
      o = 3'(phase);
      set_config(longint'($urandom_range(0, 60)) - 60, $urandom_range(0, 60),
                 longint'($urandom_range(0, 60)) - 60, $urandom_range(0, 60),
                 o, sext($urandom), sext($urandom));
      gaps_on = (phase != 3);
      for (int i = 0; i < 30; i++) send_item(random_shape());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure;
    set_config(-50, 50, -50, 50, 3'd0, 0, 0);
    hold_cycles = 150;
    for (int i = 0; i < 30; i++) send_item(random_shape());
    drain_pipeline();
    for (int i = 0; i < 10; i++) send_item(random_shape());
  endtask

  task automatic test_inverted_window;
    set_config(20, -20, 32'sh7fffffff, 32'sh80000000, 3'd7, 1, -1);
    for (int i = 0; i < 10; i++) send_item(random_shape());
  endtask

  // Receiver: random stalls, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pieces.size() == 0) begin
        $display("%0t: unexpected piece %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_pieces.pop_front();
        if (want !== out_data) begin
          $display("%0t: piece mismatch expected %h actual %h", $time, want, out_data);
          error_count++;
        end
      end
    end
  end

  initial begin
    win_l = -64'sd2147483648; win_r = 64'sd2147483647;
    win_b = -64'sd2147483648; win_t = 64'sd2147483647;
    orient = 3'd0; offs_x = 0; offs_y = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_reset_window();
    test_directed_small_window();
    test_random_orientations();
    test_backpressure();
    test_inverted_window();
    drain_pipeline();
    if (error_count == 0 && pending_pieces.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
